// ----- rtl/core/bsf_pkg.sv -----
// Package of the binary 3x3 smoothing filter: constants, types and helper functions.
package bsf_pkg;

  localparam int MaxWidth = 64;
  localparam int WidthW   = 7;
  localparam int ThrW     = 4;
  localparam int CntW     = 4;
  localparam int CfgW     = 7;
  localparam int CfgIdxW  = 2;

  localparam logic [WidthW-1:0] RowWidthReset = WidthW'(64);
  localparam logic [ThrW-1:0]   FillReset     = ThrW'(5);
  localparam logic [ThrW-1:0]   ClearReset    = ThrW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    RegRowWidth = 2'd0,
    RegFillThr  = 2'd1,
    RegClearThr = 2'd2
  } bsf_reg_e;

  typedef struct packed {
    logic [ThrW-1:0] fill;
    logic [ThrW-1:0] clear;
  } bsf_thr_t;

  typedef struct packed {
    logic [2:0] above;
    logic [2:0] here;
    logic [2:0] below;
  } bsf_win_t;

  typedef struct packed {
    logic [MaxWidth-1:0] row;
    logic                frame_end;
    logic                run_end;
  } bsf_res_t;

  typedef struct packed {
    logic [1:0] n;
    bsf_res_t   first;
    bsf_res_t   second;
  } bsf_push_t;

  function automatic logic [WidthW-1:0] active_width(input logic [WidthW-1:0] w);
    active_width = (w > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : w;
  endfunction

  function automatic logic [MaxWidth-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [MaxWidth-1:0] m;
    for (int i = 0; i < MaxWidth; i++) begin
      m[i] = (WidthW'(i) < w);
    end
    width_mask = m;
  endfunction

endpackage

// ----- rtl/core/bsf_lane.sv -----
// One smoothing lane: counts a 3x3 window and applies the fill and clear rules.
module bsf_lane (
  input  bsf_pkg::bsf_win_t win_i,
  input  bsf_pkg::bsf_thr_t thr_i,
  output logic              cell_o
);

  logic [bsf_pkg::CntW-1:0] count;

  assign count = bsf_pkg::CntW'($countones({win_i.above, win_i.here, win_i.below}));

  always_comb begin
    if (count >= thr_i.fill) begin
      cell_o = 1'b1;
    end else if (count <= thr_i.clear) begin
      cell_o = 1'b0;
    end else begin
      cell_o = win_i.here[1];
    end
  end

endmodule

// ----- rtl/core/bsf_out_fifo.sv -----
// 4-entry result queue: up to two results in per cycle, one out unless stalled.
module bsf_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsf_pkg::bsf_push_t push_i,
  output logic               almost_full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bsf_pkg::bsf_res_t  out_res_o
);

  bsf_pkg::bsf_res_t mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign out_valid_o   = (count_q != 3'd0);
  assign out_res_o     = mem_q[rd_ptr_q];
  assign pop           = out_valid_o && !out_stall_i;
  assign almost_full_o = (count_q > 3'd2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.n;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_i.n} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4) else $error("result queue count out of range");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (count_q <= 3'd2)) else $error("push without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.n == 2'd0) |=> (count_q == $past(count_q) - 3'd1))
    else $error("queue count did not drop on pop");

endmodule

// ----- rtl/core/binary_3x3_smoothing_filter.sv -----
// Binary 3x3 smoothing filter top level: row window, smoothing lanes and result queue.
// The block takes one image row per cycle and emits each row one request late, so the
// first row of a multi-row image yields no result and the last row yields two, while a
// one-row image yields one. Up to 62 interior columns are filtered at once by parallel
// lanes in the cycle a row is accepted; the results go into a four-entry queue that
// stalls input while three or more results wait, which sustains one row per cycle when
// the output is not stalled.
module binary_3x3_smoothing_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsf_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bsf_pkg::MaxWidth-1:0] row_bits_i,
  input  logic                         frame_end_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bsf_pkg::MaxWidth-1:0] smoothed_row_o,
  output logic                         frame_end_out_o,
  output logic                         run_end_o
);

  logic [bsf_pkg::WidthW-1:0]   row_width_q;
  bsf_pkg::bsf_thr_t            thr_q;
  logic [bsf_pkg::MaxWidth-1:0] upper_q, upper_d;
  logic [bsf_pkg::MaxWidth-1:0] middle_q, middle_d;
  logic [1:0]                   held_q, held_d;

  logic                         in_acc;
  logic                         almost_full;
  logic [bsf_pkg::WidthW-1:0]   width;
  logic [bsf_pkg::MaxWidth-1:0] mask;
  logic [bsf_pkg::MaxWidth-1:0] smoothed;
  logic [bsf_pkg::MaxWidth-1:0] emitted;
  bsf_pkg::bsf_push_t           push;
  bsf_pkg::bsf_res_t            out_res;

  assign in_stall_o = almost_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign width      = bsf_pkg::active_width(row_width_q);
  assign mask       = bsf_pkg::width_mask(width);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= bsf_pkg::RowWidthReset;
      thr_q.fill  <= bsf_pkg::FillReset;
      thr_q.clear <= bsf_pkg::ClearReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsf_pkg::RegRowWidth: row_width_q <= cfg_wdata_i[bsf_pkg::WidthW-1:0];
        bsf_pkg::RegFillThr:  thr_q.fill  <= cfg_wdata_i[bsf_pkg::ThrW-1:0];
        bsf_pkg::RegClearThr: thr_q.clear <= cfg_wdata_i[bsf_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign smoothed[0]                   = middle_q[0];
  assign smoothed[bsf_pkg::MaxWidth-1] = middle_q[bsf_pkg::MaxWidth-1];

  for (genvar x = 1; x < bsf_pkg::MaxWidth - 1; x++) begin : g_lane
    bsf_pkg::bsf_win_t win;
    logic              lane_bit;

    assign win.above = upper_q[x+1:x-1];
    assign win.here  = middle_q[x+1:x-1];
    assign win.below = row_bits_i[x+1:x-1];

    bsf_lane u_lane (
      .win_i  (win),
      .thr_i  (thr_q),
      .cell_o (lane_bit)
    );

    assign smoothed[x] = (width >= bsf_pkg::WidthW'(x + 2)) ? lane_bit : middle_q[x];
  end

  always_comb begin
    upper_d      = upper_q;
    middle_d     = middle_q;
    held_d       = held_q;
    push         = '0;
    emitted      = (held_q == 2'd1) ? (middle_q & mask) : (smoothed & mask);
    push.first   = '0;
    push.second  = '0;
    if (in_acc) begin
      if (held_q == 2'd0) begin
        if (frame_end_in_i) begin
          push.n               = 2'd1;
          push.first.row       = row_bits_i & mask;
          push.first.frame_end = 1'b1;
          push.first.run_end   = 1'b1;
        end else begin
          middle_d = row_bits_i;
          held_d   = 2'd1;
        end
      end else begin
        upper_d        = middle_q;
        middle_d       = row_bits_i;
        push.first.row = emitted;
        if (frame_end_in_i) begin
          push.n                = 2'd2;
          push.second.row       = row_bits_i & mask;
          push.second.frame_end = 1'b1;
          push.second.run_end   = 1'b1;
          held_d                = 2'd0;
        end else begin
          push.n             = 2'd1;
          push.first.run_end = 1'b1;
          held_d             = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      held_q   <= 2'd0;
    end else begin
      upper_q  <= upper_d;
      middle_q <= middle_d;
      held_q   <= held_d;
    end
  end

  bsf_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .almost_full_o (almost_full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_res_o     (out_res)
  );

  assign smoothed_row_o  = out_res.row;
  assign frame_end_out_o = out_res.frame_end;
  assign run_end_o       = out_res.run_end;

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 2'd3) else $error("held row count out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_end_in_i) |=> (held_q == 2'd0))
    else $error("held rows not cleared after last row");

  a_first_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !frame_end_in_i && held_q == 2'd0) |->
      (push.n == 2'd0) ##1 (held_q == 2'd1))
    else $error("first row not held");

endmodule

// ----- tb/tb_binary_3x3_smoothing_filter.sv -----
// Self-checking testbench of the binary 3x3 smoothing filter, built around a row scoreboard.
`timescale 1ns / 1ps

module tb_binary_3x3_smoothing_filter;

  class smoothing_scoreboard;
    logic [bsf_pkg::WidthW-1:0]   width_r;
    logic [bsf_pkg::ThrW-1:0]     fill_r;
    logic [bsf_pkg::ThrW-1:0]     clear_r;
    logic [bsf_pkg::MaxWidth-1:0] upper_q;
    logic [bsf_pkg::MaxWidth-1:0] middle_q;
    logic [1:0]                   held;
    bsf_pkg::bsf_res_t            rows_due[$];
    int                           mismatches;

    function new();
      width_r    = bsf_pkg::RowWidthReset;
      fill_r     = bsf_pkg::FillReset;
      clear_r    = bsf_pkg::ClearReset;
      upper_q    = '0;
      middle_q   = '0;
      held       = 2'd0;
      mismatches = 0;
    endfunction

    function void set_reg(bsf_pkg::bsf_reg_e idx, logic [bsf_pkg::CfgW-1:0] val);
      case (idx)
        bsf_pkg::RegRowWidth: width_r = val;
        bsf_pkg::RegFillThr:  fill_r  = val[bsf_pkg::ThrW-1:0];
        bsf_pkg::RegClearThr: clear_r = val[bsf_pkg::ThrW-1:0];
        default: ;
      endcase
    endfunction

    function int active_cols();
      return (width_r > bsf_pkg::MaxWidth) ? bsf_pkg::MaxWidth : int'(width_r);
    endfunction

    function logic [bsf_pkg::MaxWidth-1:0] col_mask();
      int w;
      w = active_cols();
      if (w >= bsf_pkg::MaxWidth) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    function logic [bsf_pkg::MaxWidth-1:0] smooth_window_row(
        logic [bsf_pkg::MaxWidth-1:0] above,
        logic [bsf_pkg::MaxWidth-1:0] here,
        logic [bsf_pkg::MaxWidth-1:0] below);
      int w;
      int count;
      logic [bsf_pkg::MaxWidth-1:0] res;
      w   = active_cols();
      res = here;
      for (int x = 1; x + 1 < w; x++) begin
        count = 0;
        for (int c = x - 1; c <= x + 1; c++) begin
          count += int'(above[c]) + int'(here[c]) + int'(below[c]);
        end
        if (count >= int'(fill_r)) begin
          res[x] = 1'b1;
        end else if (count <= int'(clear_r)) begin
          res[x] = 1'b0;
        end
      end
      return res & col_mask();
    endfunction

    function void push_due(logic [bsf_pkg::MaxWidth-1:0] row, logic fe, logic re);
      bsf_pkg::bsf_res_t r;
      r.row       = row;
      r.frame_end = fe;
      r.run_end   = re;
      rows_due    = {rows_due, r};
    endfunction

    function void note_row(logic [bsf_pkg::MaxWidth-1:0] row, logic last);
      logic [bsf_pkg::MaxWidth-1:0] m;
      logic [bsf_pkg::MaxWidth-1:0] emitted;
      m = col_mask();
      if (held == 2'd0) begin
        if (last) begin
          push_due(row & m, 1'b1, 1'b1);
        end else begin
          middle_q = row;
          held     = 2'd1;
        end
        return;
      end
      emitted  = (held == 2'd1) ? (middle_q & m) : smooth_window_row(upper_q, middle_q, row);
      upper_q  = middle_q;
      middle_q = row;
      if (last) begin
        push_due(emitted, 1'b0, 1'b0);
        push_due(row & m, 1'b1, 1'b1);
        held = 2'd0;
      end else begin
        push_due(emitted, 1'b0, 1'b1);
        held = 2'd2;
      end
    endfunction

    function void check_result(logic [bsf_pkg::MaxWidth-1:0] row, logic fe, logic re);
      bsf_pkg::bsf_res_t e;
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: row %h frame_end %b run_end %b", row, fe, re);
        end
        return;
      end
      e = rows_due.pop_front();
      if (row !== e.row || fe !== e.frame_end || re !== e.run_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected row %h frame_end %b run_end %b,",
                   e.row, e.frame_end, e.run_end);
          $display("          got row %h frame_end %b run_end %b", row, fe, re);
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_we       = 1'b0;
  logic [bsf_pkg::CfgIdxW-1:0]  cfg_idx      = '0;
  logic [bsf_pkg::CfgW-1:0]     cfg_wdata    = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall_o;
  logic [bsf_pkg::MaxWidth-1:0] row_bits     = '0;
  logic                         frame_end_in = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall    = 1'b0;
  logic [bsf_pkg::MaxWidth-1:0] smoothed_row_o;
  logic                         frame_end_out_o;
  logic                         run_end_o;

  int idle_pct  = 0;
  int stall_pct = 0;
  int rows_left = 0;

  smoothing_scoreboard sb = new();

  binary_3x3_smoothing_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .row_bits_i      (row_bits),
    .frame_end_in_i  (frame_end_in),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .smoothed_row_o  (smoothed_row_o),
    .frame_end_out_o (frame_end_out_o),
    .run_end_o       (run_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_stall_o === 1'b0) begin
        sb.note_row(row_bits, frame_end_in);
      end
      if (out_valid_o === 1'b1 && !out_stall) begin
        sb.check_result(smoothed_row_o, frame_end_out_o, run_end_o);
      end
    end
  end

  task automatic send_row(input logic [bsf_pkg::MaxWidth-1:0] row, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    row_bits     <= row;
    frame_end_in <= last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.rows_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [bsf_pkg::CfgW-1:0] w,
                              input logic [bsf_pkg::CfgW-1:0] f,
                              input logic [bsf_pkg::CfgW-1:0] c);
    cfg_we    <= 1'b1;
    cfg_idx   <= bsf_pkg::RegRowWidth;
    cfg_wdata <= w;
    sb.set_reg(bsf_pkg::RegRowWidth, w);
    @(posedge clk_i);
    cfg_idx   <= bsf_pkg::RegFillThr;
    cfg_wdata <= f;
    sb.set_reg(bsf_pkg::RegFillThr, f);
    @(posedge clk_i);
    cfg_idx   <= bsf_pkg::RegClearThr;
    cfg_wdata <= c;
    sb.set_reg(bsf_pkg::RegClearThr, c);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [bsf_pkg::MaxWidth-1:0] random_row();
    logic [bsf_pkg::MaxWidth-1:0] a;
    logic [bsf_pkg::MaxWidth-1:0] b;
    logic [bsf_pkg::MaxWidth-1:0] r;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: r = a & b;
      1: r = a | b;
      2: r = a & b & {$urandom, $urandom};
      3: r = a | b | {$urandom, $urandom};
      default: r = a;
    endcase
    return r;
  endfunction

  task automatic send_random_row();
    if (rows_left == 0) begin
      case ($urandom_range(0, 9))
        0: rows_left = 1;
        9: rows_left = $urandom_range(10, 30);
        default: rows_left = $urandom_range(2, 6);
      endcase
    end
    send_row(random_row(), rows_left == 1);
    rows_left--;
  endtask

  initial begin
    int p;
    int w;
    int f;
    int c;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row('1, 1'b0);
    send_row('0, 1'b0);
    send_row({32{2'b10}}, 1'b0);
    send_row({32{2'b01}}, 1'b0);
    send_row('1, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('1, 1'b0);
    send_row(64'h0123_4567_89AB_CDEF, 1'b1);
    drain_block();
    apply_config(7'd3, 7'd0, 7'd15);
    send_row('1, 1'b0);
    send_row(64'd5, 1'b0);
    send_row(64'd2, 1'b1);
    drain_block();
    apply_config(7'd0, 7'd5, 7'd3);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    drain_block();
    apply_config(7'd1, 7'd5, 7'd3);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    drain_block();
    apply_config(7'd2, 7'd5, 7'd3);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    drain_block();
    apply_config(7'd127, 7'd15, 7'd0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b1);
    drain_block();
    apply_config(7'd64, 7'd10, 7'd9);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b1);
    drain_block();

    for (p = 0; p < 12; p++) begin
      case (p)
        0: begin w = 64; f = 5; c = 3; end
        1: begin w = 3; f = 5; c = 3; end
        2: begin w = 64; f = 0; c = 0; end
        3: begin w = 127; f = 9; c = 9; end
        4: begin w = 0; f = 5; c = 3; end
        5: begin w = 1; f = 5; c = 3; end
        6: begin w = 2; f = 4; c = 4; end
        7: begin w = 63; f = 15; c = 15; end
        default: begin
          w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 64);
          f = $urandom_range(0, 15);
          c = $urandom_range(0, 15);
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 79; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 79; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      apply_config(bsf_pkg::CfgW'(w), bsf_pkg::CfgW'(f), bsf_pkg::CfgW'(c));
      repeat (130) send_random_row();
      drain_block();
    end

    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.rows_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
